// ===== hw/rtl/gpmr_pkg.sv =====
package gpmr_pkg;

    // access kinds
    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_opcode;

    // clause-22 register numbers
    localparam logic [4:0] REG_CONTROL  = 5'd0;
    localparam logic [4:0] REG_STATUS   = 5'd1;
    localparam logic [4:0] REG_ID_HI    = 5'd2;
    localparam logic [4:0] REG_ID_LO    = 5'd3;
    localparam logic [4:0] REG_ADVERT   = 5'd4;
    localparam logic [4:0] REG_PARTNER  = 5'd5;
    localparam logic [4:0] REG_AN_EXP   = 5'd6;
    localparam logic [4:0] REG_GIG_CTL  = 5'd9;
    localparam logic [4:0] REG_GIG_STAT = 5'd10;
    localparam logic [4:0] REG_EXT_STAT = 5'd15;

    // configuration register indexes
    localparam logic CFG_PHY_ID      = 1'b0;
    localparam logic CFG_STATUS_BITS = 1'b1;

    // defaults and fixed words
    localparam logic [15:0] CTL_DEFAULT      = 16'h1140;
    localparam logic [15:0] ADV_DEFAULT      = 16'h01e1;
    localparam logic [15:0] GIG_DEFAULT      = 16'h0300;
    localparam logic [15:0] PARTNER_WORD     = 16'h41e1;
    localparam logic [15:0] AN_EXP_WORD      = 16'h0001;
    localparam logic [15:0] GIG_STAT_WORD    = 16'h3c00;
    localparam logic [15:0] EXT_STAT_WORD    = 16'h3000;
    localparam logic [15:0] STAT_LINK_BITS   = 16'h0024;
    localparam logic [15:0] CTL_SELF_CLEAR   = 16'h8200;
    localparam logic [31:0] PHY_ID_DEFAULT   = 32'h0000_0000;
    localparam logic [15:0] STATUS_DEFAULT   = 16'h7949;

    // control register bit positions
    localparam int CTL_BIT_RESET    = 15;
    localparam int CTL_BIT_SPEED100 = 13;
    localparam int CTL_BIT_ANEG_EN  = 12;
    localparam int CTL_BIT_FULLDUP  = 8;
    localparam int CTL_BIT_SPEED1G  = 6;

    // resolved speed codes
    localparam logic [1:0] SPEED_10   = 2'd0;
    localparam logic [1:0] SPEED_100  = 2'd1;
    localparam logic [1:0] SPEED_1000 = 2'd2;

    typedef struct packed {
        t_opcode     opcode;
        logic [4:0]  reg_addr;
        logic [15:0] write_data;
        logic        link_up;
    } t_access;

    typedef struct packed {
        logic [15:0] read_data;
        logic [1:0]  link_speed;
        logic        full_duplex;
    } t_result;

    typedef struct packed {
        logic [31:0] phy_identifier;
        logic [15:0] status_static_bits;
    } t_cfg;

endpackage

// ===== hw/rtl/gpmr_if.sv =====
interface gpmr_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [4:0]  reg_addr;
    logic [15:0] write_data;
    logic        link_up;

    modport source (output valid, output opcode, output reg_addr, output write_data,
                    output link_up, input ready);
    modport sink   (input valid, input opcode, input reg_addr, input write_data,
                    input link_up, output ready);
endinterface

interface gpmr_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic [1:0]  link_speed;
    logic        full_duplex;

    modport source (output valid, output read_data, output link_speed,
                    output full_duplex, input ready);
    modport sink   (input valid, input read_data, input link_speed,
                    input full_duplex, output ready);
endinterface

// ===== hw/rtl/gigabit_phy_mii_registers.sv =====
// Register side of a gigabit PHY as seen over the management bus.
// i_req carries one read or write of a clause-22 register plus the current
// carrier state; o_rsp returns one result per transfer: read data (zero on
// writes and unknown registers) and the speed and duplex resolved after
// the access.
// The APB port holds the PHY identifier (byte address 0) and the static
// status capability bits (byte address 4); write it only while idle.
// An input transfer reaches the result shown through the input register,
// then the result register fed by the register file mux and the
// speed/duplex resolve logic. One transfer per cycle is sustained unless
// o_rsp stalls; the state is updated as an item leaves the input register.
// While o_rsp is stalled the result register holds, one more item waits in
// the input register, and i_req.ready drops once both are full.
// Reset returns control to 0x1140, advertisement to 0x01e1, 1000BASE-T
// control to 0x0300, the identifier to zero and status bits to 0x7949,
// and drops both valid flags.
module gigabit_phy_mii_registers (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gpmr_req_if.sink    i_req,
    gpmr_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    gpmr_pkg::t_cfg      r_cfg;
    gpmr_pkg::t_access   r_s1_acc;
    gpmr_pkg::t_result   r_out_res;
    gpmr_pkg::t_result   res;
    logic                r_s1_valid, n_s1_valid;
    logic                r_out_valid, n_out_valid;
    logic                s2_can;
    logic                s1_fire;
    logic                in_ready;
    logic                in_fire;
    logic                cfg_wr;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phy_identifier     <= gpmr_pkg::PHY_ID_DEFAULT;
            r_cfg.status_static_bits <= gpmr_pkg::STATUS_DEFAULT;
        end else if (cfg_wr) begin
            if (paddr[2] == gpmr_pkg::CFG_PHY_ID) begin
                r_cfg.phy_identifier <= pwdata;
            end else begin
                r_cfg.status_static_bits <= pwdata[15:0];
            end
        end
    end

    assign prdata = (paddr[2] == gpmr_pkg::CFG_PHY_ID) ? r_cfg.phy_identifier
                                                       : {16'h0000, r_cfg.status_static_bits};

    // pipeline flow control
    assign s2_can   = !r_out_valid || o_rsp.ready;
    assign s1_fire  = r_s1_valid && s2_can;
    assign in_ready = !r_s1_valid || s2_can;
    assign in_fire  = i_req.valid && in_ready;
    assign i_req.ready = in_ready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_fire) begin
            n_s1_valid = 1'b1;
        end else if (s1_fire) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_fire) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_acc.opcode     <= gpmr_pkg::t_opcode'(i_req.opcode);
            r_s1_acc.reg_addr   <= i_req.reg_addr;
            r_s1_acc.write_data <= i_req.write_data;
            r_s1_acc.link_up    <= i_req.link_up;
        end
    end

    gpmr_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_acc   (r_s1_acc),
        .i_fire  (s1_fire),
        .o_res   (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_res <= res;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_data   = r_out_res.read_data;
    assign o_rsp.link_speed  = r_out_res.link_speed;
    assign o_rsp.full_duplex = r_out_res.full_duplex;

    // checks
    a_hold_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s2_can) |=> (r_s1_valid && $stable(r_s1_acc)))
        else $error("input register lost an item during a stall");

    a_speed_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.link_speed != 2'd3))
        else $error("invalid speed code");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_s1_valid && !o_rsp.valid))
        else $error("pipeline not empty after reset");

    a_ready_when_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_req.ready)
        else $error("input stalled with an empty result register");

endmodule

// ===== hw/rtl/gpmr_regfile.sv =====
module gpmr_regfile (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gpmr_pkg::t_cfg    i_cfg,
    input  gpmr_pkg::t_access i_acc,
    input  logic             i_fire,
    output gpmr_pkg::t_result o_res
);

    logic [15:0] r_ctl, n_ctl;
    logic [15:0] r_adv, n_adv;
    logic [15:0] r_gig, n_gig;
    logic [15:0] rd;
    logic [1:0]  speed;
    logic        duplex;

    // register writes, reset bit restores control, advert and gig defaults
    always_comb begin
        n_ctl = r_ctl;
        n_adv = r_adv;
        n_gig = r_gig;
        if (i_fire && i_acc.opcode == gpmr_pkg::OP_WRITE) begin
            case (i_acc.reg_addr)
                gpmr_pkg::REG_CONTROL: begin
                    if (i_acc.write_data[gpmr_pkg::CTL_BIT_RESET]) begin
                        n_ctl = gpmr_pkg::CTL_DEFAULT;
                        n_adv = gpmr_pkg::ADV_DEFAULT;
                        n_gig = gpmr_pkg::GIG_DEFAULT;
                    end else begin
                        n_ctl = i_acc.write_data & ~gpmr_pkg::CTL_SELF_CLEAR;
                    end
                end
                gpmr_pkg::REG_ADVERT:  n_adv = i_acc.write_data;
                gpmr_pkg::REG_GIG_CTL: n_gig = i_acc.write_data;
                default: ;
            endcase
        end
    end

    // read mux, writes return zero
    always_comb begin
        rd = 16'h0000;
        if (i_acc.opcode == gpmr_pkg::OP_READ) begin
            case (i_acc.reg_addr)
                gpmr_pkg::REG_CONTROL:  rd = r_ctl;
                gpmr_pkg::REG_STATUS:   rd = i_cfg.status_static_bits |
                                             (i_acc.link_up ? gpmr_pkg::STAT_LINK_BITS
                                                            : 16'h0000);
                gpmr_pkg::REG_ID_HI:    rd = i_cfg.phy_identifier[31:16];
                gpmr_pkg::REG_ID_LO:    rd = i_cfg.phy_identifier[15:0];
                gpmr_pkg::REG_ADVERT:   rd = r_adv;
                gpmr_pkg::REG_PARTNER:  rd = gpmr_pkg::PARTNER_WORD;
                gpmr_pkg::REG_AN_EXP:   rd = gpmr_pkg::AN_EXP_WORD;
                gpmr_pkg::REG_GIG_CTL:  rd = r_gig;
                gpmr_pkg::REG_GIG_STAT: rd = gpmr_pkg::GIG_STAT_WORD;
                gpmr_pkg::REG_EXT_STAT: rd = gpmr_pkg::EXT_STAT_WORD;
                default:                rd = 16'h0000;
            endcase
        end
    end

    // speed and duplex from the state as it stands after the access
    always_comb begin
        if (n_ctl[gpmr_pkg::CTL_BIT_ANEG_EN]) begin
            if (n_gig[9] || n_gig[8]) begin
                speed  = gpmr_pkg::SPEED_1000;
                duplex = n_gig[9];
            end else if (n_adv[8] || n_adv[7]) begin
                speed  = gpmr_pkg::SPEED_100;
                duplex = n_adv[8];
            end else begin
                speed  = gpmr_pkg::SPEED_10;
                duplex = n_adv[6];
            end
        end else begin
            if (n_ctl[gpmr_pkg::CTL_BIT_SPEED1G]) begin
                speed = gpmr_pkg::SPEED_1000;
            end else if (n_ctl[gpmr_pkg::CTL_BIT_SPEED100]) begin
                speed = gpmr_pkg::SPEED_100;
            end else begin
                speed = gpmr_pkg::SPEED_10;
            end
            duplex = n_ctl[gpmr_pkg::CTL_BIT_FULLDUP];
        end
    end

    assign o_res.read_data   = rd;
    assign o_res.link_speed  = speed;
    assign o_res.full_duplex = duplex;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= gpmr_pkg::CTL_DEFAULT;
            r_adv <= gpmr_pkg::ADV_DEFAULT;
            r_gig <= gpmr_pkg::GIG_DEFAULT;
        end else begin
            r_ctl <= n_ctl;
            r_adv <= n_adv;
            r_gig <= n_gig;
        end
    end

endmodule
